// ----- sv/utsc_pkg.sv -----
`default_nettype none
// ============================================================================
// utsc_pkg: shared types and constants of the UTF-8 token scanner
// Token kind codes and fixed field widths used by the scanner and its top.
// ============================================================================
package utsc_pkg;

  // width of the token kind field
  localparam int KIND_W = 3;

  // width of a decoded rune
  localparam int RUNE_W = 21;

  // width of the rune byte count (one to four bytes)
  localparam int NBYTES_W = 3;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SEMI = 3'd0,
    KIND_PLUS = 3'd1,
    KIND_NEG  = 3'd2,
    KIND_NUM  = 3'd3,
    KIND_ERR  = 3'd4,
    KIND_EOF  = 3'd5
  } kind_t;

endpackage
`default_nettype wire

// ----- sv/utsc_lex.sv -----
`default_nettype none
// ============================================================================
// utsc_lex: UTF-8 decode and token generation
// Holds the running scanner state and turns one accepted beat into up to two
// tokens: a closed number first, then the token of the current rune or eof.
// ============================================================================
module utsc_lex #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int TOK_W       = 3 + 2 * 32 + 16 + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic             op,
  input  wire logic [7:0]       source_byte,
  output logic      [1:0]       tok_cnt,
  output logic      [TOK_W-1:0] tok0,
  output logic      [TOK_W-1:0] tok1
);
  import utsc_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int LB = LENGTH_BITS;
  localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  // characters of interest
  localparam logic [RUNE_W-1:0] CH_TAB  = 21'h09;
  localparam logic [RUNE_W-1:0] CH_LF   = 21'h0A;
  localparam logic [RUNE_W-1:0] CH_CR   = 21'h0D;
  localparam logic [RUNE_W-1:0] CH_SP   = 21'h20;
  localparam logic [RUNE_W-1:0] CH_PLUS = 21'h2B;
  localparam logic [RUNE_W-1:0] CH_D0   = 21'h30;
  localparam logic [RUNE_W-1:0] CH_D9   = 21'h39;
  localparam logic [RUNE_W-1:0] CH_SEMI = 21'h3B;
  localparam logic [RUNE_W-1:0] CH_NEG  = 21'hAF;

  // scanner state
  logic [1:0]          pend_r,      pend_nxt;
  logic [RUNE_W-1:0]   acc_r,       acc_nxt;
  logic [NBYTES_W-1:0] rbytes_r,    rbytes_nxt;
  logic [OB-1:0]       rstart_r,    rstart_nxt;
  logic [OB-1:0]       off_r,       off_nxt;
  logic [OB-1:0]       line_r,      line_nxt;
  logic                in_num_r,    in_num_nxt;
  logic [OB-1:0]       num_start_r, num_start_nxt;
  logic [LB-1:0]       num_len_r,   num_len_nxt;

  // per-beat working values
  logic                lex_go;
  logic                bad;
  logic                digit;
  logic [RUNE_W-1:0]   rune;
  logic [RUNE_W-1:0]   acc_new;
  logic [OB-1:0]       rbegin;
  logic [NBYTES_W-1:0] nbytes;
  logic [LB:0]         len_sum;
  logic                c0_v, c1_v, c2_v;
  kind_t               c1_kind;
  logic [OB-1:0]       c1_start;
  logic [TOK_W-2:0]    c0, c1, c2;
  logic [1:0]          n_all;

  // next state and token candidates
  always_comb begin
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    rbytes_nxt    = rbytes_r;
    rstart_nxt    = rstart_r;
    off_nxt       = off_r;
    line_nxt      = line_r;
    in_num_nxt    = in_num_r;
    num_start_nxt = num_start_r;
    num_len_nxt   = num_len_r;
    lex_go        = 1'b0;
    bad           = 1'b0;
    rune          = '0;
    rbegin        = off_r;
    nbytes        = NBYTES_W'(1);
    c0_v          = 1'b0;
    c1_v          = 1'b0;
    c2_v          = 1'b0;
    c1_kind       = KIND_ERR;
    c1_start      = off_r;
    acc_new       = {acc_r[RUNE_W-7:0], source_byte[5:0]};
    len_sum       = '0;
    digit         = 1'b0;

    if (take) begin
      if (op) begin
        // end of source: flush a cut-short rune or a number, then eof if room
        if (pend_r != 2'd0) begin
          lex_go   = 1'b1;
          bad      = 1'b1;
          rbegin   = rstart_r;
          nbytes   = rbytes_r;
          pend_nxt = 2'd0;
          acc_nxt  = '0;
        end else begin
          c0_v       = in_num_r;
          in_num_nxt = 1'b0;
        end
        c2_v = 1'b1;
      end else begin
        if (pend_r == 2'd0) begin
          // lead byte
          if (source_byte[7] == 1'b0) begin
            lex_go = 1'b1;
            rune   = RUNE_W'(source_byte[6:0]);
          end else if (source_byte[7:5] == 3'b110) begin
            pend_nxt   = 2'd1;
            rbytes_nxt = NBYTES_W'(2);
            acc_nxt    = RUNE_W'(source_byte[4:0]);
            rstart_nxt = off_r;
          end else if (source_byte[7:4] == 4'b1110) begin
            pend_nxt   = 2'd2;
            rbytes_nxt = NBYTES_W'(3);
            acc_nxt    = RUNE_W'(source_byte[3:0]);
            rstart_nxt = off_r;
          end else if (source_byte[7:3] == 5'b11110) begin
            pend_nxt   = 2'd3;
            rbytes_nxt = NBYTES_W'(4);
            acc_nxt    = RUNE_W'(source_byte[2:0]);
            rstart_nxt = off_r;
          end else begin
            lex_go = 1'b1;
            bad    = 1'b1;
          end
        end else begin
          // continuation byte
          acc_nxt  = acc_new;
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            lex_go = 1'b1;
            rune   = acc_new;
            rbegin = rstart_r;
            nbytes = rbytes_r;
          end
        end
        off_nxt = (off_r == OFF_MAX) ? off_r : off_r + OB'(1);
      end
    end

    // lex one complete rune
    if (lex_go) begin
      digit   = !bad && (rune >= CH_D0) && (rune <= CH_D9);
      len_sum = {1'b0, num_len_r} + (LB+1)'(nbytes);
      if (digit && in_num_r) begin
        num_len_nxt = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LB-1:0];
      end else begin
        c0_v       = in_num_r;
        in_num_nxt = 1'b0;
        c1_start   = rbegin;
        if (bad) begin
          c1_v    = 1'b1;
          c1_kind = KIND_ERR;
        end else if (rune == CH_LF) begin
          c1_v     = 1'b1;
          c1_kind  = KIND_SEMI;
          line_nxt = (line_r == OFF_MAX) ? line_r : line_r + OB'(1);
        end else if (rune == CH_SP || (rune >= CH_TAB && rune <= CH_CR)) begin
          c1_v = 1'b0;
        end else if (rune == CH_SEMI) begin
          c1_v    = 1'b1;
          c1_kind = KIND_SEMI;
        end else if (rune == CH_PLUS) begin
          c1_v    = 1'b1;
          c1_kind = KIND_PLUS;
        end else if (rune == CH_NEG) begin
          c1_v    = 1'b1;
          c1_kind = KIND_NEG;
        end else if (digit) begin
          in_num_nxt    = 1'b1;
          num_start_nxt = rbegin;
          num_len_nxt   = LB'(nbytes);
        end else begin
          c1_v    = 1'b1;
          c1_kind = KIND_ERR;
        end
      end
    end
  end

  // candidate tokens: line, length, start, kind
  assign c0 = {line_r, num_len_r, num_start_r, KIND_NUM};
  assign c1 = {line_r, {LB{1'b0}}, c1_start, c1_kind};
  assign c2 = {line_r, {LB{1'b0}}, off_r, KIND_EOF};

  // pack the first two candidates, last flag on the final one
  assign n_all = 2'(c0_v) + 2'(c1_v) + 2'(c2_v);
  always_comb begin
    tok_cnt = (n_all > 2'd2) ? 2'd2 : n_all;
    if (c0_v) begin
      tok0 = {1'b0, c0};
      tok1 = c1_v ? {1'b1, c1} : {1'b1, c2};
    end else if (c1_v) begin
      tok0 = {1'b0, c1};
      tok1 = {1'b1, c2};
    end else begin
      tok0 = {1'b0, c2};
      tok1 = {1'b1, c2};
    end
    if (tok_cnt == 2'd1) begin
      tok0[TOK_W-1] = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      acc_r       <= '0;
      rbytes_r    <= '0;
      rstart_r    <= '0;
      off_r       <= '0;
      line_r      <= '0;
      in_num_r    <= 1'b0;
      num_start_r <= '0;
      num_len_r   <= '0;
    end else begin
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      rbytes_r    <= rbytes_nxt;
      rstart_r    <= rstart_nxt;
      off_r       <= off_nxt;
      line_r      <= line_nxt;
      in_num_r    <= in_num_nxt;
      num_start_r <= num_start_nxt;
      num_len_r   <= num_len_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utsc_fifo.sv -----
`default_nettype none
// ============================================================================
// utsc_fifo: token queue
// Small circular queue that takes zero, one or two tokens per cycle and
// hands out at most one. DEPTH must be a power of two and at least two.
// ============================================================================
module utsc_fifo #(
  parameter int WIDTH = 84,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       wr_cnt,
  input  wire logic [WIDTH-1:0] wr0,
  input  wire logic [WIDTH-1:0] wr1,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  not_empty,
  output logic                  room2
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;

  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign rd_data   = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(rd_en);
    count_nxt  = count_r + CW'(wr_cnt) - CW'(rd_en);
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr_r + AW'(1)] <= wr1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utf8_token_scanner.sv -----
`default_nettype none
// ============================================================================
// utf8_token_scanner: byte-serial UTF-8 token scanner
// Decodes UTF-8 source text and emits semicolon, plus, negative, number,
// error and end-of-file tokens.
// ============================================================================
// Usage
//   Input channel: one beat per source byte (in_tuser = 0) or an end-of-source
//   mark (in_tuser = 1). A beat may be taken in every cycle with in_tready.
//   Output channel: one beat per token; out_tlast marks the final token caused
//   by an input beat. An input beat gives zero, one or two tokens.
//   Queue: the tokens of a taken beat are registered into the token queue
//   and offered from its head in order.
//   Throughput: one input beat per cycle while in_tready is high; the
//   output drains one token per cycle from a four-entry queue while
//   out_tready is high. in_tready is high while the queue has room for two
//   tokens, so the input keeps flowing while a token waits, and stalls only
//   once the receiver has let more than two tokens collect in the queue.
//   Reset: clears the offset, line and number counters, any partial rune and
//   the token queue.
// ============================================================================
module utf8_token_scanner #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] source_byte
  input  wire logic                 in_tuser,   // [0] op
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [2:0] token_kind, then token_start, token_length, token_line, zero pad
  output logic [((utsc_pkg::KIND_W + 2 * OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0]
                                    out_tdata,
  output logic                      out_tlast   // last_of_run
);
  import utsc_pkg::*;

  localparam int FIELDS_W = KIND_W + 2 * OFFSET_BITS + LENGTH_BITS;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int TOK_W    = FIELDS_W + 1;
  localparam int Q_DEPTH  = 4;

  logic             take;
  logic [1:0]       tok_cnt;
  logic [TOK_W-1:0] tok0, tok1;
  logic [TOK_W-1:0] head;
  logic             room2;

  // input handshake
  assign in_tready = room2;
  assign take      = in_tvalid & in_tready;

  // scanner
  utsc_lex #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS),
    .TOK_W      (TOK_W)
  ) u_lex (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .op         (in_tuser),
    .source_byte(in_tdata),
    .tok_cnt    (tok_cnt),
    .tok0       (tok0),
    .tok1       (tok1)
  );

  // token queue
  utsc_fifo #(
    .WIDTH(TOK_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (tok_cnt),
    .wr0      (tok0),
    .wr1      (tok1),
    .rd_en    (out_tvalid & out_tready),
    .rd_data  (head),
    .not_empty(out_tvalid),
    .room2    (room2)
  );

  // output beat
  assign out_tdata = TDATA_W'(head[FIELDS_W-1:0]);
  assign out_tlast = head[TOK_W-1];

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the utf8_token_scanner
// Feeds directed and random UTF-8 source bytes and end marks, predicts every
// token with an in-bench scanner model, and checks each output beat in order.
// ============================================================================
module tb;
  import utsc_pkg::*;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int OUT_W = ((KIND_W + 2 * OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8;
  localparam int START_LSB = KIND_W;
  localparam int LEN_LSB = START_LSB + OFFSET_BITS;
  localparam int LINE_LSB = LEN_LSB + LENGTH_BITS;

  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES = 100;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1700;

  // input beat kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END = 1'b1;

  // characters with a meaning to the scanner
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [20:0] RUNE_NEG = 21'h0000AF;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [31:0] line;
    logic        last;
  } token_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h00;
  logic             in_tuser = OP_BYTE;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  // scanner model state
  logic [1:0]  dec_pending;
  logic [20:0] dec_acc;
  logic [31:0] dec_rune_start;
  logic [2:0]  dec_rune_bytes;
  logic [31:0] scan_offset;
  logic [31:0] scan_line;
  logic        num_open;
  logic [31:0] num_start;
  logic [15:0] num_len;

  token_t step_tokens[2];
  int     step_count;
  token_t expected_tokens[$];
  token_t want;

  int  mismatches = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  idle_on = 1'b1;

  utf8_token_scanner #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------

  // record a token for the current beat, at most two per beat
  task automatic emit_token(input kind_t kind, input logic [31:0] start,
                            input logic [15:0] len);
    if (step_count < 2) begin
      step_tokens[step_count] = '{kind, start, len, scan_line, 1'b0};
      step_count++;
    end
  endtask

  task automatic close_number();
    if (num_open) begin
      emit_token(KIND_NUM, num_start, num_len);
      num_open = 1'b0;
    end
  endtask

  // classify one finished rune
  task automatic lex_rune(input logic [20:0] rune, input logic bad,
                          input logic [31:0] start, input logic [2:0] nbytes);
    logic digit;
    digit = !bad && rune >= 21'(CH_ZERO) && rune <= 21'(CH_NINE);
    if (digit && num_open) begin
      if (32'(num_len) + 32'(nbytes) > 32'hFFFF) num_len = 16'hFFFF;
      else num_len = num_len + 16'(nbytes);
    end else begin
      close_number();
      if (bad) begin
        emit_token(KIND_ERR, start, 16'd0);
      end else if (rune == 21'(CH_NL)) begin
        emit_token(KIND_SEMI, start, 16'd0);
        if (scan_line != '1) scan_line++;
      end else if (rune == 21'(CH_SPACE) ||
                   (rune >= 21'(CH_TAB) && rune <= 21'(CH_CR))) begin
        // whitespace makes no token
      end else if (rune == 21'(CH_SEMI)) begin
        emit_token(KIND_SEMI, start, 16'd0);
      end else if (rune == 21'(CH_PLUS)) begin
        emit_token(KIND_PLUS, start, 16'd0);
      end else if (rune == RUNE_NEG) begin
        emit_token(KIND_NEG, start, 16'd0);
      end else if (digit) begin
        num_open = 1'b1;
        num_start = start;
        num_len = 16'(nbytes);
      end else begin
        emit_token(KIND_ERR, start, 16'd0);
      end
    end
  endtask

  // advance the model by one accepted beat and queue its tokens
  task automatic predict_tokens(input logic op, input logic [7:0] b);
    token_t tok;
    logic [1:0] need;
    logic [20:0] payload;
    logic bad;
    step_count = 0;
    if (op == OP_END) begin
      if (dec_pending != 0) begin
        lex_rune(21'd0, 1'b1, dec_rune_start, dec_rune_bytes);
        dec_pending = 0;
        dec_acc = 0;
      end else begin
        close_number();
      end
      emit_token(KIND_EOF, scan_offset, 16'd0);
    end else begin
      if (dec_pending == 0) begin
        need = 0;
        payload = 0;
        bad = 1'b0;
        if ((b & 8'h80) == 8'h00) payload = 21'(b & 8'h7F);
        else if ((b & 8'hE0) == 8'hC0) begin
          need = 1;
          payload = 21'(b & 8'h1F);
        end else if ((b & 8'hF0) == 8'hE0) begin
          need = 2;
          payload = 21'(b & 8'h0F);
        end else if ((b & 8'hF8) == 8'hF0) begin
          need = 3;
          payload = 21'(b & 8'h07);
        end else bad = 1'b1;
        if (need == 0) begin
          lex_rune(payload, bad, scan_offset, 3'd1);
        end else begin
          dec_pending = need;
          dec_rune_bytes = 3'(need) + 3'd1;
          dec_acc = payload;
          dec_rune_start = scan_offset;
        end
      end else begin
        dec_acc = {dec_acc[14:0], b[5:0]};
        dec_pending--;
        if (dec_pending == 0) lex_rune(dec_acc, 1'b0, dec_rune_start, dec_rune_bytes);
      end
      if (scan_offset != '1) scan_offset++;
    end
    for (int i = 0; i < step_count; i++) begin
      tok = step_tokens[i];
      tok.last = (i == step_count - 1);
      expected_tokens.push_back(tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one beat after a random gap, wait for acceptance, then predict
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predict_tokens(op, b);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: ready pattern and token check
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h",
               $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: unexpected token, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tdata[KIND_W-1:0]));
        check_field("start", want.start, out_tdata[START_LSB +: OFFSET_BITS]);
        check_field("length", 32'(want.len), 32'(out_tdata[LEN_LSB +: LENGTH_BITS]));
        check_field("line", want.line, out_tdata[LINE_LSB +: OFFSET_BITS]);
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
      stall_left = idle_on ? $urandom_range(0, 5) : 0;
    end
    // long hold-off on request, else short per-beat stalls
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one-byte tokens, whitespace, plain errors
  task automatic test_single_tokens();
    send_beat(OP_BYTE, CH_PLUS);
    send_beat(OP_BYTE, CH_NL);
    send_beat(OP_BYTE, CH_TAB);
    send_beat(OP_BYTE, CH_SEMI);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h7F);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h80);
  endtask

  // numbers with overlong digits, negative sign, multi-byte non-ascii
  task automatic test_runes_and_numbers();
    send_beat(OP_BYTE, 8'h31);
    send_beat(OP_BYTE, CH_NINE);
    send_beat(OP_BYTE, 8'hC0);
    send_beat(OP_BYTE, 8'hB0);
    send_beat(OP_BYTE, CH_SEMI);
    send_beat(OP_BYTE, 8'hC2);
    send_beat(OP_BYTE, 8'hAF);
    send_beat(OP_BYTE, 8'hF0);
    send_beat(OP_BYTE, 8'h9F);
    send_beat(OP_BYTE, 8'h98);
    send_beat(OP_BYTE, 8'h80);
  endtask

  // end marks with open number, cut-short rune, both, and bytes after end
  task automatic test_end_marks();
    send_beat(OP_BYTE, 8'h35);
    send_beat(OP_BYTE, 8'hE2);
    send_beat(OP_END, 8'h00);
    send_beat(OP_END, 8'hFF);
    send_beat(OP_BYTE, 8'hE1);
    send_beat(OP_END, 8'h00);
    send_beat(OP_BYTE, CH_ZERO);
    send_beat(OP_END, 8'h00);
  endtask

  // receiver stops for a long stretch while number/plus pairs keep coming
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (20) begin
      send_beat(OP_BYTE, 8'h37);
      send_beat(OP_BYTE, CH_PLUS);
    end
    idle_on = 1'b1;
  endtask

  // one random lexeme, mostly well-formed, some noise
  task automatic send_random_lexeme();
    int pick, k;
    logic [7:0] d, lead;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k = $urandom_range(1, 6);
      repeat (k) begin
        d = 8'($urandom_range(0, 9));
        case ($urandom_range(0, 11))
          0: begin
            send_beat(OP_BYTE, 8'hC0);
            send_beat(OP_BYTE, 8'hB0 + d);
          end
          1: begin
            send_beat(OP_BYTE, 8'hE0);
            send_beat(OP_BYTE, 8'h80);
            send_beat(OP_BYTE, 8'hB0 + d);
          end
          2: begin
            send_beat(OP_BYTE, 8'hF0);
            send_beat(OP_BYTE, 8'h80);
            send_beat(OP_BYTE, 8'h80);
            send_beat(OP_BYTE, 8'hB0 + d);
          end
          default: send_beat(OP_BYTE, CH_ZERO + d);
        endcase
      end
    end else if (pick < 40) begin
      send_beat(OP_BYTE, CH_PLUS);
    end else if (pick < 48) begin
      send_beat(OP_BYTE, CH_SEMI);
    end else if (pick < 56) begin
      send_beat(OP_BYTE, CH_NL);
    end else if (pick < 66) begin
      k = $urandom_range(0, 5);
      send_beat(OP_BYTE, (k == 5) ? CH_SPACE : CH_TAB + 8'(k));
    end else if (pick < 72) begin
      send_beat(OP_BYTE, 8'hC2);
      send_beat(OP_BYTE, 8'hAF);
    end else if (pick < 80) begin
      // well-formed multi-byte rune with random payload
      k = $urandom_range(1, 3);
      case (k)
        1: lead = {3'b110, 5'($urandom)};
        2: lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_beat(OP_BYTE, lead);
      repeat (k) send_beat(OP_BYTE, {2'b10, 6'($urandom)});
    end else if (pick < 87) begin
      send_beat(OP_BYTE, {1'b0, 7'($urandom)});
    end else if (pick < 95) begin
      send_beat(OP_BYTE, 8'($urandom));
    end else if (pick < 98) begin
      // rune cut short by an end mark
      k = $urandom_range(1, 3);
      case (k)
        1: lead = {3'b110, 5'($urandom)};
        2: lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_beat(OP_BYTE, lead);
      repeat ($urandom_range(0, k - 1)) send_beat(OP_BYTE, {2'b10, 6'($urandom)});
      send_beat(OP_END, 8'($urandom));
    end else begin
      send_beat(OP_END, 8'($urandom));
    end
  endtask

  // random text in blocks, some blocks without any idling
  task automatic test_random_text();
    int block_end;
    for (int blk = 0; items_sent < ITEM_TARGET; blk++) begin
      idle_on = (blk % 3 != 1);
      block_end = items_sent + 200;
      while (items_sent < block_end && items_sent < ITEM_TARGET) send_random_lexeme();
    end
    idle_on = 1'b1;
  endtask

  // flush whatever number or rune is still open
  task automatic test_final_end();
    send_beat(OP_END, 8'h00);
  endtask

  initial begin
    dec_pending = 0;
    dec_acc = 0;
    dec_rune_start = 0;
    dec_rune_bytes = 0;
    scan_offset = 0;
    scan_line = 0;
    num_open = 1'b0;
    num_start = 0;
    num_len = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_tokens();
    test_runes_and_numbers();
    test_end_marks();
    test_backpressure();
    test_random_text();
    test_final_end();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
